>>> src/mcos_pkg.sv
package mcos_pkg;

  // Default configuration
  localparam int unsigned MAX_MATRICES_DEF = 16;
  localparam int unsigned DIM_BITS_DEF     = 12;
  localparam int unsigned COST_BITS_DEF    = 48;

  // Fixed field widths of the channels
  localparam int unsigned DIM_W  = 12;
  localparam int unsigned IDX_W  = 4;
  localparam int unsigned COST_W = 48;

  typedef enum logic [1:0] {
    KIND_SPLIT = 2'd0,
    KIND_TOTAL = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] dimension;
    logic             final_dimension;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  first_matrix;
    logic [IDX_W-1:0]  last_matrix;
    logic [IDX_W-1:0]  split_after;
    logic [COST_W-1:0] total_cost;
    logic              end_of_run;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_DIAG,
    ST_IVL_A,
    ST_IVL_B,
    ST_IVL_C,
    ST_K_RD,
    ST_K_MUL1,
    ST_K_MUL2,
    ST_K_ACC,
    ST_IVL_WR,
    ST_WALK_INIT,
    ST_POP,
    ST_NODE_RD,
    ST_NODE,
    ST_PUSH2,
    ST_TOTAL_RD,
    ST_TOTAL
  } state_e;

  typedef struct packed {
    logic load;
    logic clr_chain;
    logic diag_wr;
    logic ivl_start;
    logic rd_dj1;
    logic cap_dj1;
    logic k_rd;
    logic k_mul1;
    logic k_mul2;
    logic k_acc;
    logic ivl_wr;
    logic walk_init;
    logic pop;
    logic node_rd;
    logic node_emit;
    logic push2;
    logic total_rd;
    logic emit_total;
    logic emit_err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic err;
    logic diag_last;
    logic one_matrix;
    logic k_last;
    logic ivl_last;
    logic len_last;
    logic stack_empty;
    logic leaf;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/mcos_ctrl.sv
module mcos_ctrl import mcos_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_final_i,
  output logic       req_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (req_valid_i && req_final_i) state_d = ST_CHECK;
      ST_CHECK:     state_d = status_i.err ? ST_ERR : ST_DIAG;
      ST_ERR:       if (status_i.out_free) state_d = ST_IDLE;
      ST_DIAG: begin
        if (status_i.diag_last) state_d = status_i.one_matrix ? ST_WALK_INIT : ST_IVL_A;
      end
      ST_IVL_A:     state_d = ST_IVL_B;
      ST_IVL_B:     state_d = ST_IVL_C;
      ST_IVL_C:     state_d = ST_K_RD;
      ST_K_RD:      state_d = ST_K_MUL1;
      ST_K_MUL1:    state_d = ST_K_MUL2;
      ST_K_MUL2:    state_d = ST_K_ACC;
      ST_K_ACC:     state_d = status_i.k_last ? ST_IVL_WR : ST_K_RD;
      ST_IVL_WR: begin
        state_d = (status_i.ivl_last && status_i.len_last) ? ST_WALK_INIT : ST_IVL_A;
      end
      ST_WALK_INIT: state_d = ST_POP;
      ST_POP:       state_d = status_i.stack_empty ? ST_TOTAL_RD : ST_NODE_RD;
      ST_NODE_RD:   state_d = status_i.leaf ? ST_POP : ST_NODE;
      ST_NODE:      if (status_i.out_free) state_d = ST_PUSH2;
      ST_PUSH2:     state_d = ST_POP;
      ST_TOTAL_RD:  state_d = ST_TOTAL;
      ST_TOTAL:     if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o       = '0;
    req_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE:      cmd_o.load = req_valid_i;
      ST_ERR: begin
        cmd_o.emit_err  = status_i.out_free;
        cmd_o.clr_chain = status_i.out_free;
      end
      ST_DIAG:      cmd_o.diag_wr = 1'b1;
      ST_IVL_A:     cmd_o.ivl_start = 1'b1;
      ST_IVL_B:     cmd_o.rd_dj1 = 1'b1;
      ST_IVL_C:     cmd_o.cap_dj1 = 1'b1;
      ST_K_RD:      cmd_o.k_rd = 1'b1;
      ST_K_MUL1:    cmd_o.k_mul1 = 1'b1;
      ST_K_MUL2:    cmd_o.k_mul2 = 1'b1;
      ST_K_ACC:     cmd_o.k_acc = 1'b1;
      ST_IVL_WR:    cmd_o.ivl_wr = 1'b1;
      ST_WALK_INIT: cmd_o.walk_init = 1'b1;
      ST_POP:       cmd_o.pop = !status_i.stack_empty;
      ST_NODE_RD:   cmd_o.node_rd = !status_i.leaf;
      ST_NODE:      cmd_o.node_emit = status_i.out_free;
      ST_PUSH2:     cmd_o.push2 = 1'b1;
      ST_TOTAL_RD:  cmd_o.total_rd = 1'b1;
      ST_TOTAL: begin
        cmd_o.emit_total = status_i.out_free;
        cmd_o.clr_chain  = status_i.out_free;
      end
      default:      cmd_o = '0;
    endcase
  end

endmodule

>>> src/mcos_dpath.sv
module mcos_dpath import mcos_pkg::*; #(
  parameter int unsigned MaxMatrices = MAX_MATRICES_DEF,
  parameter int unsigned DimBits     = DIM_BITS_DEF,
  parameter int unsigned CostBits    = COST_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  req_t       req_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o,
  input  logic       rsp_stall_i
);

  localparam int unsigned IW = $clog2(MaxMatrices);
  localparam int unsigned SW = $clog2(MaxMatrices + 1);
  localparam int unsigned CW = $clog2(MaxMatrices + 2);
  localparam int unsigned TD = 1 << (2 * IW);
  localparam int unsigned PW = 3 * DimBits;
  localparam int unsigned WW = (PW > CostBits) ? PW : CostBits;

  function automatic logic [CostBits-1:0] sat_add(input logic [CostBits-1:0] a,
                                                  input logic [CostBits-1:0] b);
    logic [CostBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostBits] ? {CostBits{1'b1}} : s[CostBits-1:0];
  endfunction

  // chain store and counters
  logic [CW-1:0]        count_q;
  logic                 ovf_q;
  logic [DimBits-1:0]   dim_mem [MaxMatrices+1];
  logic [DimBits-1:0]   dim_rdata_q;
  logic [SW-1:0]        dim_raddr;
  logic                 dim_re;

  logic [IW-1:0]        i_q, j_q, k_q;
  logic [CW-1:0]        len_q;
  logic [CW-1:0]        nm, nm_m1;
  logic [IW-1:0]        k_p1;

  // tables
  logic [CostBits-1:0]  cost_mem [TD];
  logic [IW-1:0]        split_mem [TD];
  logic [CostBits-1:0]  cost_rd0_q, cost_rd1_q;
  logic [IW-1:0]        split_rd_q;
  logic [2*IW-1:0]      cw_addr, cr_addr0, cr_addr1;
  logic [CostBits-1:0]  cw_data;
  logic [IW-1:0]        sw_data;
  logic                 tbl_we, cost_re;

  // arithmetic
  logic [DimBits-1:0]   d_i_q, d_j1_q;
  logic [2*DimBits-1:0] p1_q;
  logic [CostBits-1:0]  csum_q, p_q, best_q, q_cand;
  logic [IW-1:0]        bk_q;
  logic [PW-1:0]        p2;
  logic [WW-1:0]        p2_w, cost_max_w;

  // walk stack
  logic [IW-1:0]        stk_lo [MaxMatrices+1];
  logic [IW-1:0]        stk_hi [MaxMatrices+1];
  logic [CW-1:0]        sp_q, sp_m1;
  logic [IW-1:0]        lo_q, hi_q;

  // result register
  rsp_t                 rsp_q;
  logic                 rsp_valid_q;
  logic                 out_free;

  assign nm    = count_q - CW'(1);
  assign nm_m1 = nm - CW'(1);
  assign k_p1  = k_q + IW'(1);
  assign sp_m1 = sp_q - CW'(1);
  assign out_free = !rsp_valid_q || !rsp_stall_i;

  always_comb begin
    status_o.err         = ovf_q || (count_q < CW'(2));
    status_o.diag_last   = (CW'(i_q) == nm_m1);
    status_o.one_matrix  = (nm == CW'(1));
    status_o.k_last      = (k_q == j_q - IW'(1));
    status_o.ivl_last    = (CW'(j_q) == nm_m1);
    status_o.len_last    = (len_q == nm);
    status_o.stack_empty = (sp_q == '0);
    status_o.leaf        = (lo_q >= hi_q);
    status_o.out_free    = out_free;
  end

  // dimension read address
  always_comb begin
    dim_re    = cmd_i.ivl_start || cmd_i.rd_dj1 || cmd_i.k_rd;
    dim_raddr = SW'(k_p1);
    if (cmd_i.ivl_start) begin
      dim_raddr = SW'(i_q);
    end else if (cmd_i.rd_dj1) begin
      dim_raddr = SW'(j_q) + SW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (count_q < CW'(MaxMatrices + 1))) begin
      dim_mem[count_q[SW-1:0]] <= DimBits'(req_i.dimension);
    end
    if (dim_re) begin
      dim_rdata_q <= dim_mem[dim_raddr];
    end
  end

  // table ports
  always_comb begin
    tbl_we   = cmd_i.diag_wr || cmd_i.ivl_wr;
    cw_addr  = cmd_i.diag_wr ? {i_q, i_q} : {i_q, j_q};
    cw_data  = cmd_i.diag_wr ? '0 : best_q;
    sw_data  = cmd_i.diag_wr ? i_q : bk_q;
    cost_re  = cmd_i.k_rd || cmd_i.total_rd;
    cr_addr0 = cmd_i.total_rd ? {IW'(0), nm_m1[IW-1:0]} : {i_q, k_q};
    cr_addr1 = {k_p1, j_q};
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      cost_mem[cw_addr]  <= cw_data;
      split_mem[cw_addr] <= sw_data;
    end
    if (cost_re) begin
      cost_rd0_q <= cost_mem[cr_addr0];
      cost_rd1_q <= cost_mem[cr_addr1];
    end
    if (cmd_i.node_rd) begin
      split_rd_q <= split_mem[{lo_q, hi_q}];
    end
  end

  // candidate cost: two multiplies, each registered, then saturate and compare
  assign p2         = PW'(p1_q) * PW'(d_j1_q);
  assign p2_w       = WW'(p2);
  assign cost_max_w = WW'({CostBits{1'b1}});
  assign q_cand     = sat_add(csum_q, p_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_dj1)  d_i_q  <= dim_rdata_q;
    if (cmd_i.cap_dj1) d_j1_q <= dim_rdata_q;
    if (cmd_i.k_mul1) begin
      p1_q   <= (2*DimBits)'(d_i_q) * (2*DimBits)'(dim_rdata_q);
      csum_q <= sat_add(cost_rd0_q, cost_rd1_q);
    end
    if (cmd_i.k_mul2) begin
      p_q <= (p2_w > cost_max_w) ? {CostBits{1'b1}} : CostBits'(p2_w);
    end
    if (cmd_i.k_acc && ((k_q == i_q) || (q_cand < best_q))) begin
      best_q <= q_cand;
      bk_q   <= k_q;
    end
  end

  // stack storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      stk_lo[0] <= '0;
      stk_hi[0] <= nm_m1[IW-1:0];
    end
    if (cmd_i.pop) begin
      lo_q <= stk_lo[sp_m1[SW-1:0]];
      hi_q <= stk_hi[sp_m1[SW-1:0]];
    end
    if (cmd_i.node_emit) begin
      stk_lo[sp_q[SW-1:0]] <= split_rd_q + IW'(1);
      stk_hi[sp_q[SW-1:0]] <= hi_q;
    end
    if (cmd_i.push2) begin
      stk_lo[sp_q[SW-1:0]] <= lo_q;
      stk_hi[sp_q[SW-1:0]] <= split_rd_q;
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      len_q   <= '0;
      sp_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        if (count_q < CW'(MaxMatrices + 1)) begin
          count_q <= count_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clr_chain) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
      if (cmd_i.diag_wr) begin
        if (status_o.diag_last) begin
          i_q   <= '0;
          len_q <= CW'(2);
        end else begin
          i_q <= i_q + IW'(1);
        end
      end
      if (cmd_i.ivl_start) begin
        j_q <= IW'(CW'(i_q) + len_q - CW'(1));
        k_q <= i_q;
      end
      if (cmd_i.k_acc) begin
        k_q <= k_p1;
      end
      if (cmd_i.ivl_wr) begin
        if (status_o.ivl_last) begin
          i_q   <= '0;
          len_q <= len_q + CW'(1);
        end else begin
          i_q <= i_q + IW'(1);
        end
      end
      if (cmd_i.walk_init) begin
        sp_q <= CW'(1);
      end
      if (cmd_i.pop) begin
        sp_q <= sp_m1;
      end
      if (cmd_i.node_emit || cmd_i.push2) begin
        sp_q <= sp_q + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.node_emit || cmd_i.emit_total || cmd_i.emit_err) begin
      rsp_valid_q <= 1'b1;
    end else if (!rsp_stall_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_emit) begin
      rsp_q.kind         <= KIND_SPLIT;
      rsp_q.first_matrix <= IDX_W'(lo_q);
      rsp_q.last_matrix  <= IDX_W'(hi_q);
      rsp_q.split_after  <= IDX_W'(split_rd_q);
      rsp_q.total_cost   <= '0;
      rsp_q.end_of_run   <= 1'b0;
    end else if (cmd_i.emit_total) begin
      rsp_q.kind         <= KIND_TOTAL;
      rsp_q.first_matrix <= '0;
      rsp_q.last_matrix  <= IDX_W'(nm_m1);
      rsp_q.split_after  <= '0;
      rsp_q.total_cost   <= COST_W'(cost_rd0_q);
      rsp_q.end_of_run   <= 1'b1;
    end else if (cmd_i.emit_err) begin
      rsp_q.kind         <= KIND_ERROR;
      rsp_q.first_matrix <= '0;
      rsp_q.last_matrix  <= '0;
      rsp_q.split_after  <= '0;
      rsp_q.total_cost   <= '0;
      rsp_q.end_of_run   <= 1'b1;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> src/matrix_chain_order_solver.sv
// Channel   Handshake               Payload  Direction
// request   req_valid_i/req_stall_o req_i    in: one chain dimension per request
// result    rsp_valid_o/rsp_stall_i rsp_o    out: split nodes, then total or error
//
// Requests that are not final are taken one per cycle and stored.
// A final request starts the table fill, which checks n(n*n-1)/6 split candidates
// for n matrices, one at a time, in the shared multiply-and-compare unit. The walk
// then pops each subchain, reads its split and, if not a leaf, emits it and pushes both halves.
// Reset clears the chain count and the sequencer; the tables need no clearing.
// A stalled result holds the walk; no request is taken until the run ends.
module matrix_chain_order_solver import mcos_pkg::*; #(
  parameter int unsigned MaxMatrices = MAX_MATRICES_DEF,
  parameter int unsigned DimBits     = DIM_BITS_DEF,
  parameter int unsigned CostBits    = COST_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_stall_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_stall_i,
  output rsp_t rsp_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: loading, table fill, preorder walk
  mcos_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_final_i (req_i.final_dimension),
    .req_stall_o (req_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // stores, tables, cost arithmetic, walk stack and result register
  mcos_dpath #(
    .MaxMatrices (MaxMatrices),
    .DimBits     (DimBits),
    .CostBits    (CostBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .rsp_stall_i (rsp_stall_i)
  );

endmodule
